// ===== rtl/tdec_pkg.sv =====
package tdec_pkg;

    // Queue depths, powers of two so that the pointers wrap by themselves
    localparam int MID_DEPTH = 2;
    localparam int RES_DEPTH = 4;

    // Characters the decoder looks for
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [15:0] CODE_NEWLINE = 16'd10;

    // Input beat
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_end;
    } in_item_t;

    // Result beat
    typedef struct packed {
        logic [15:0] code_unit;
        logic        run_last;
        logic        string_done;
    } out_item_t;

    // Classified input beat, front to back
    typedef struct packed {
        in_item_t item;
        logic     is_open;
        logic     is_close;
        logic     is_lead;
    } cls_item_t;

endpackage

// ===== rtl/tdec_front.sv =====
module tdec_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  tdec_pkg::in_item_t   item,
    output logic                 q_vld,
    output tdec_pkg::cls_item_t  q_head,
    input  logic                 deq
);
    import tdec_pkg::*;

    localparam int PTR_W = $clog2(MID_DEPTH);
    localparam int CNT_W = $clog2(MID_DEPTH + 1);

    cls_item_t          slot_reg [MID_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   fill_next;
    cls_item_t          cls;
    logic               enq;

    // Classify the incoming byte
    always_comb
    begin
        cls.item     = item;
        cls.is_open  = (item.in_byte == CH_OPEN);
        cls.is_close = (item.in_byte == CH_CLOSE);
        cls.is_lead  = item.in_byte[7];
    end

    assign full   = (fill_reg == CNT_W'(MID_DEPTH));
    assign enq    = push && !full;
    assign q_vld  = (fill_reg != '0);
    assign q_head = slot_reg[rd_ptr_reg];

    // Track the fill level
    always_comb
    begin
        fill_next = fill_reg;
        if (enq && !deq)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (deq && !enq)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    // Advance the pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (enq)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (deq)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    // Hold the classified beats
    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ===== rtl/tdec_back.sv =====
module tdec_back #(
    parameter int MAX_COMMAND = 15
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_vld,
    input  tdec_pkg::cls_item_t  q_head,
    output logic                 deq,
    input  logic                 rq_full,
    output logic                 rq_push,
    output tdec_pkg::out_item_t  rq_data
);
    import tdec_pkg::*;

    localparam int CNT_W = $clog2(MAX_COMMAND + 1);
    localparam int IDX_W = $clog2(MAX_COMMAND);

    typedef enum logic [3:0] {
        ST_TEXT = 4'b0001,
        ST_LEAD = 4'b0010,
        ST_CMD  = 4'b0100,
        ST_NUM  = 4'b1000
    } st_t;

    st_t               st_reg,        st_next;
    logic [CNT_W-1:0]  cnt_reg,       cnt_next;
    logic [7:0]        lead_reg,      lead_next;
    logic [15:0]       val_reg,       val_next;
    logic              used_reg,      used_next;
    logic              held_vld_reg,  held_vld_next;
    logic [15:0]       held_code_reg, held_code_next;
    logic              flush_reg,     flush_next;
    logic [7:0]        cmd_reg [MAX_COMMAND];

    logic              go;
    logic              fin;
    logic [7:0]        in_byte;
    logic [7:0]        rb;
    logic              replay;
    logic              rb_last;
    logic              rb_digit;
    logic [7:0]        digit_val;
    logic [15:0]       val_step;
    logic              is_br;
    logic              is_u;
    logic              cnt_full;
    logic [CNT_W-1:0]  cnt_dec;
    logic [CNT_W-1:0]  cnt_inc;
    logic              e_vld;
    logic [15:0]       e_code;
    logic              act_final;
    logic              shift_en;
    logic              app_en;
    logic              retire;

    assign go        = q_vld && !rq_full;
    assign fin       = q_head.item.in_end;
    assign in_byte   = q_head.item.in_byte;
    assign rb        = cmd_reg[0];
    assign replay    = ((st_reg == ST_TEXT) || (st_reg == ST_LEAD)) && (cnt_reg != '0);
    assign rb_last   = (cnt_reg == CNT_W'(1)) && used_reg;
    assign rb_digit  = rb inside {[CH_ZERO:CH_NINE]};
    assign digit_val = rb - CH_ZERO;
    assign val_step  = {val_reg[12:0], 3'b000} + {val_reg[14:0], 1'b0} + {8'h00, digit_val};
    assign is_br     = (cnt_reg == CNT_W'(2)) && (cmd_reg[0] == CH_B) && (cmd_reg[1] == CH_R);
    assign is_u      = (cnt_reg != '0) && (cmd_reg[0] == CH_U);
    assign cnt_full  = (cnt_reg == CNT_W'(MAX_COMMAND));
    assign cnt_dec   = cnt_reg - CNT_W'(1);
    assign cnt_inc   = cnt_reg + CNT_W'(1);

    // One action per cycle when go is set; codes may wait in the held slot
    always_comb
    begin
        st_next        = st_reg;
        cnt_next       = cnt_reg;
        lead_next      = lead_reg;
        val_next       = val_reg;
        used_next      = used_reg;
        held_vld_next  = held_vld_reg;
        held_code_next = held_code_reg;
        flush_next     = flush_reg;
        e_vld          = 1'b0;
        e_code         = '0;
        act_final      = 1'b0;
        shift_en       = 1'b0;
        app_en         = 1'b0;
        retire         = 1'b0;
        rq_push        = 1'b0;
        rq_data        = '0;

        if (go)
        begin
            if (flush_reg)
            begin
                // close the item with the held code
                act_final = 1'b1;
            end
            else if (st_reg == ST_NUM)
            begin
                // accumulate decimal digits of a numeric command, then emit its value
                if ((cnt_reg == '0) || !rb_digit)
                begin
                    e_vld     = 1'b1;
                    e_code    = val_reg;
                    act_final = 1'b1;
                    st_next   = ST_TEXT;
                    cnt_next  = '0;
                end
                else
                begin
                    val_next = val_step;
                    shift_en = 1'b1;
                    cnt_next = cnt_dec;
                end
            end
            else if ((st_reg == ST_CMD) && used_reg)
            begin
                // judge a command cut short by the end of the string
                if (is_br)
                begin
                    e_vld     = 1'b1;
                    e_code    = CODE_NEWLINE;
                    act_final = 1'b1;
                    st_next   = ST_TEXT;
                    cnt_next  = '0;
                end
                else if (is_u)
                begin
                    st_next  = ST_NUM;
                    shift_en = 1'b1;
                    cnt_next = cnt_dec;
                    val_next = '0;
                end
                else
                begin
                    e_vld     = 1'b1;
                    e_code    = {8'h00, CH_OPEN};
                    st_next   = ST_TEXT;
                    act_final = (cnt_reg == '0);
                end
            end
            else if (replay)
            begin
                // decode the oldest byte of a rejected command again
                shift_en = 1'b1;
                cnt_next = cnt_dec;
                if (st_reg == ST_LEAD)
                begin
                    e_vld     = 1'b1;
                    e_code    = {5'b00000, lead_reg[4:0], rb[5:0]};
                    st_next   = ST_TEXT;
                    act_final = rb_last;
                end
                else if (rb == CH_OPEN)
                begin
                    if (rb_last)
                    begin
                        e_vld     = 1'b1;
                        e_code    = {8'h00, CH_OPEN};
                        act_final = 1'b1;
                    end
                    else
                    begin
                        // the rest of the buffer becomes the new command
                        st_next = ST_CMD;
                    end
                end
                else if (rb[7])
                begin
                    if (rb_last)
                    begin
                        e_vld     = 1'b1;
                        e_code    = {5'b00000, rb[4:0], 6'b000000};
                        act_final = 1'b1;
                    end
                    else
                    begin
                        st_next   = ST_LEAD;
                        lead_next = rb;
                    end
                end
                else
                begin
                    e_vld     = 1'b1;
                    e_code    = {8'h00, rb};
                    act_final = rb_last;
                end
            end
            else
            begin
                // take the byte of the current beat
                case (st_reg)
                    ST_TEXT:
                    begin
                        act_final = 1'b1;
                        if (q_head.is_open)
                        begin
                            if (fin)
                            begin
                                e_vld  = 1'b1;
                                e_code = {8'h00, CH_OPEN};
                            end
                            else
                            begin
                                st_next  = ST_CMD;
                                cnt_next = '0;
                            end
                        end
                        else if (q_head.is_lead)
                        begin
                            if (fin)
                            begin
                                e_vld  = 1'b1;
                                e_code = {5'b00000, in_byte[4:0], 6'b000000};
                            end
                            else
                            begin
                                st_next   = ST_LEAD;
                                lead_next = in_byte;
                            end
                        end
                        else
                        begin
                            e_vld  = 1'b1;
                            e_code = {8'h00, in_byte};
                        end
                    end
                    ST_LEAD:
                    begin
                        e_vld     = 1'b1;
                        e_code    = {5'b00000, lead_reg[4:0], in_byte[5:0]};
                        act_final = 1'b1;
                        st_next   = ST_TEXT;
                    end
                    ST_CMD:
                    begin
                        if (cnt_full || q_head.is_close)
                        begin
                            if (is_br)
                            begin
                                e_vld     = 1'b1;
                                e_code    = CODE_NEWLINE;
                                act_final = 1'b1;
                                st_next   = ST_TEXT;
                                cnt_next  = '0;
                                used_next = 1'b1;
                            end
                            else if (is_u)
                            begin
                                st_next   = ST_NUM;
                                shift_en  = 1'b1;
                                cnt_next  = cnt_dec;
                                val_next  = '0;
                                used_next = 1'b1;
                            end
                            else
                            begin
                                // reject: replay the buffer, then this byte
                                e_vld   = 1'b1;
                                e_code  = {8'h00, CH_OPEN};
                                st_next = ST_TEXT;
                            end
                        end
                        else
                        begin
                            app_en    = 1'b1;
                            cnt_next  = cnt_inc;
                            used_next = 1'b1;
                            act_final = !fin;
                        end
                    end
                    default:
                    begin
                        st_next = ST_TEXT;
                    end
                endcase
            end

            // Stage codes so the last one of a beat can carry run_last
            if (e_vld && held_vld_reg)
            begin
                rq_push           = 1'b1;
                rq_data.code_unit = held_code_reg;
                held_code_next    = e_code;
                if (act_final)
                begin
                    flush_next = 1'b1;
                end
            end
            else if (e_vld)
            begin
                if (act_final)
                begin
                    rq_push             = 1'b1;
                    rq_data.code_unit   = e_code;
                    rq_data.run_last    = 1'b1;
                    rq_data.string_done = fin;
                    retire              = 1'b1;
                end
                else
                begin
                    held_vld_next  = 1'b1;
                    held_code_next = e_code;
                end
            end
            else if (act_final)
            begin
                if (held_vld_reg)
                begin
                    rq_push             = 1'b1;
                    rq_data.code_unit   = held_code_reg;
                    rq_data.run_last    = 1'b1;
                    rq_data.string_done = fin;
                    held_vld_next       = 1'b0;
                end
                retire = 1'b1;
            end

            if (retire)
            begin
                used_next  = 1'b0;
                flush_next = 1'b0;
            end
        end
    end

    assign deq = retire;

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= ST_TEXT;
            cnt_reg      <= '0;
            used_reg     <= 1'b0;
            held_vld_reg <= 1'b0;
            flush_reg    <= 1'b0;
        end
        else
        begin
            st_reg       <= st_next;
            cnt_reg      <= cnt_next;
            used_reg     <= used_next;
            held_vld_reg <= held_vld_next;
            flush_reg    <= flush_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        lead_reg      <= lead_next;
        val_reg       <= val_next;
        held_code_reg <= held_code_next;
    end

    // Shift out the oldest command byte, or append a new one
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            for (int i = 0; i < MAX_COMMAND - 1; i++)
            begin
                cmd_reg[i] <= cmd_reg[i + 1];
            end
        end
        else if (app_en)
        begin
            cmd_reg[cnt_reg[IDX_W-1:0]] <= in_byte;
        end
    end

endmodule

// ===== rtl/tdec_rq.sv =====
module tdec_rq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  tdec_pkg::out_item_t  wr_data,
    input  logic                 pop,
    output logic                 empty,
    output tdec_pkg::out_item_t  rd_data
);
    import tdec_pkg::*;

    localparam int PTR_W = $clog2(RES_DEPTH);
    localparam int CNT_W = $clog2(RES_DEPTH + 1);

    out_item_t          slot_reg [RES_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   fill_next;
    logic               wr_en;
    logic               rd_en;

    assign full    = (fill_reg == CNT_W'(RES_DEPTH));
    assign empty   = (fill_reg == '0);
    assign wr_en   = push && !full;
    assign rd_en   = pop && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    // Track the fill level
    always_comb
    begin
        fill_next = fill_reg;
        if (wr_en && !rd_en)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    // Advance the pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    // Hold the result beats
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/escape_and_utf8_text_decoder.sv =====
// Channel   Handshake      Payload          Beat
// input     push / full    item   (8+1b)    one byte of the string, end flag
// result    empty / pop    result (16+1+1b) one code unit, last-of-step, end of string
//
// Steps: the back end decodes a plain byte, a two-byte pair or a buffered command byte
// as one action; when the last code of a step comes right after another code of that
// step, a further action closes the step. A rejected command emits its bracket and
// then replays the buffered bytes one at a time, a numeric command takes its digits one
// at a time, and every replayed byte can open a command that is rejected again; all of
// this is run by the single back-end sequencer.
// Reset: rst_n clears queues and decoder state at once; no clearing pass is needed.
// Stalls: a two-beat queue decouples intake from decode; decode holds while the
// four-beat result queue is full.
module escape_and_utf8_text_decoder #(
    parameter int MAX_COMMAND = 15
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  tdec_pkg::in_item_t   item,
    output logic                 empty,
    input  logic                 pop,
    output tdec_pkg::out_item_t  result
);
    import tdec_pkg::*;

    logic       q_vld;
    cls_item_t  q_head;
    logic       deq;
    logic       rq_full;
    logic       rq_push;
    out_item_t  rq_data;

    tdec_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .q_vld  (q_vld),
        .q_head (q_head),
        .deq    (deq)
    );

    tdec_back #(
        .MAX_COMMAND (MAX_COMMAND)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_vld   (q_vld),
        .q_head  (q_head),
        .deq     (deq),
        .rq_full (rq_full),
        .rq_push (rq_push),
        .rq_data (rq_data)
    );

    tdec_rq u_rq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (rq_push),
        .full    (rq_full),
        .wr_data (rq_data),
        .pop     (pop),
        .empty   (empty),
        .rd_data (result)
    );

endmodule

// ===== sim/escape_and_utf8_text_decoder_tb.sv =====
`timescale 1ns / 1ps

module escape_and_utf8_text_decoder_tb;

    import tdec_pkg::*;

    localparam int CMD_MAX     = 15;
    localparam int MAX_RES     = CMD_MAX + 2;
    localparam int TOTAL_ITEMS = 430;
    localparam int HOLD_AT     = 120;
    localparam int HOLD_LEN    = 400;
    localparam int MID_PAUSE   = 260;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    logic        push  = 1'b0;
    logic        pop   = 1'b0;
    logic        full;
    logic        empty;
    in_item_t    item  = '0;
    out_item_t   result;

    // Stimulus and expected code units
    in_item_t    pend_q [$];
    out_item_t   code_q [$];
    logic [7:0]  str_q [$];

    // Decoder state as the testbench sees it
    logic [7:0]  cmd_bytes [0:CMD_MAX-1];
    int unsigned cmd_len   = 0;
    bit          in_cmd    = 1'b0;
    logic [7:0]  lead_hold = 8'h00;
    bit          lead_wait = 1'b0;
    logic [7:0]  scan_buf [0:MAX_RES-1];

    // Run statistics
    int          err_cnt      = 0;
    int          bytes_in     = 0;
    int          strings_in   = 0;
    int          units_out    = 0;
    int          esc_taken    = 0;
    int          esc_rejected = 0;
    int          pairs_seen   = 0;
    int          directed_n   = 0;
    int          loaded_cnt   = 0;
    int          cycles       = 0;

    // Handshake pacing
    int          gap_left  = 0;
    int          wait_left = 0;
    int          hold_left = 0;
    bit          calm_tx   = 1'b0;
    bit          calm_rx   = 1'b0;
    bit          took      = 1'b0;
    bit          hold_tx   = 1'b0;
    out_item_t   exp_unit;

    escape_and_utf8_text_decoder DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Decode one byte and queue the code units it releases
    function automatic void predict_codes(input in_item_t beat);
        int unsigned len, i, k, cnt, j, n;
        bit          fin, stop, ok, digits, has_next;
        logic [7:0]  c, c2;
        logic [31:0] val;
        logic [15:0] codes [0:MAX_RES-1];
        out_item_t   r;
        len  = 0;
        i    = 0;
        n    = 0;
        stop = 1'b0;
        fin  = beat.in_end;

        // rebuild the byte run: held lead or open command, then the new byte
        if (lead_wait)
        begin
            scan_buf[len] = lead_hold;
            len++;
        end
        else if (in_cmd)
        begin
            scan_buf[len] = CH_OPEN;
            len++;
            for (j = 0; j < cmd_len; j++)
            begin
                scan_buf[len] = cmd_bytes[j];
                len++;
            end
        end
        scan_buf[len] = beat.in_byte;
        len++;
        lead_wait = 1'b0;
        in_cmd    = 1'b0;
        cmd_len   = 0;

        while (i < len && !stop)
        begin
            c = scan_buf[i];
            if (c == CH_OPEN)
            begin
                // find the close bracket, the length cap or the end of the run
                k = 1;
                while (k <= CMD_MAX && i + k < len && scan_buf[i + k] != CH_CLOSE)
                    k++;
                cnt = k - 1;
                if (i + k >= len && !fin)
                begin
                    in_cmd  = 1'b1;
                    cmd_len = cnt;
                    for (j = 0; j < cnt; j++)
                        cmd_bytes[j] = scan_buf[i + 1 + j];
                    stop = 1'b1;
                end
                else
                begin
                    ok  = 1'b0;
                    val = 32'd0;
                    if (cnt == 2 && scan_buf[i + 1] == CH_B && scan_buf[i + 2] == CH_R)
                    begin
                        ok  = 1'b1;
                        val = {16'h0000, CODE_NEWLINE};
                    end
                    else if (cnt >= 1 && scan_buf[i + 1] == CH_U)
                    begin
                        ok     = 1'b1;
                        digits = 1'b1;
                        for (j = 1; j < cnt; j++)
                        begin
                            c2 = scan_buf[i + 1 + j];
                            if (c2 < CH_ZERO || c2 > CH_NINE)
                                digits = 1'b0;
                            if (digits)
                                val = (val * 10 + (c2 - CH_ZERO)) & 32'h0000_FFFF;
                        end
                    end
                    if (ok)
                    begin
                        codes[n] = val[15:0];
                        i += cnt + 2;
                        esc_taken++;
                    end
                    else
                    begin
                        // rejected: emit the bracket and rescan what follows it
                        codes[n] = {8'h00, CH_OPEN};
                        i += 1;
                        esc_rejected++;
                    end
                    n++;
                end
            end
            else if (c[7])
            begin
                has_next = (i + 1 < len);
                if (has_next || fin)
                begin
                    c2 = has_next ? scan_buf[i + 1] : 8'h00;
                    codes[n] = {5'b00000, c[4:0], c2[5:0]};
                    n++;
                    i += has_next ? 2 : 1;
                    pairs_seen++;
                end
                else
                begin
                    lead_wait = 1'b1;
                    lead_hold = c;
                    stop      = 1'b1;
                end
            end
            else
            begin
                codes[n] = {8'h00, c};
                n++;
                i++;
            end
        end

        // flag the last unit of the step
        for (j = 0; j < n; j++)
        begin
            r.code_unit   = codes[j];
            r.run_last    = (j == n - 1);
            r.string_done = fin && (j == n - 1);
            code_q.push_back(r);
        end
    endfunction

    task automatic push_byte(input logic [7:0] b, input bit last);
        in_item_t it;
        it.in_byte = b;
        it.in_end  = last;
        pend_q.push_back(it);
    endtask

    task automatic push_text(input string s);
        int idx;
        for (idx = 0; idx < s.len(); idx++)
            push_byte(s[idx], idx == s.len() - 1);
    endtask

    // Pick a byte for a command body, weighted toward the interesting ones
    function automatic logic [7:0] cmd_byte();
        logic [7:0] b;
        case ($urandom_range(0, 7))
            0: b = CH_B;
            1: b = CH_R;
            2: b = CH_U;
            3, 4: b = 8'($urandom_range(CH_ZERO, CH_NINE));
            5: b = CH_CLOSE;
            6: b = 8'($urandom_range(32, 126));
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    // Build one random string of tokens and queue it, end flag on the last byte
    task automatic add_string();
        int         ntok, t, m, idx;
        logic [7:0] b;
        str_q.delete();
        ntok = $urandom_range(1, 8);
        for (t = 0; t < ntok; t++)
        begin
            case ($urandom_range(0, 11))
                0, 1, 2:
                begin
                    b = 8'($urandom_range(32, 126));
                    str_q.push_back(b);
                end
                3, 4:
                begin
                    b = 8'($urandom_range(128, 255));
                    str_q.push_back(b);
                    b = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(128, 191))
                                                    : 8'($urandom_range(0, 255));
                    str_q.push_back(b);
                end
                5:
                begin
                    str_q.push_back(CH_OPEN);
                    str_q.push_back(CH_B);
                    str_q.push_back(CH_R);
                    str_q.push_back(CH_CLOSE);
                end
                6, 7:
                begin
                    // numeric escape, now and then long enough to wrap or fill up
                    str_q.push_back(CH_OPEN);
                    str_q.push_back(CH_U);
                    m = ($urandom_range(0, 6) == 0) ? $urandom_range(6, 16)
                                                    : $urandom_range(0, 5);
                    for (idx = 0; idx < m; idx++)
                    begin
                        b = 8'($urandom_range(CH_ZERO, CH_NINE));
                        str_q.push_back(b);
                    end
                    if ($urandom_range(0, 5) != 0)
                        str_q.push_back(CH_CLOSE);
                end
                8:
                begin
                    str_q.push_back(CH_OPEN);
                    m = $urandom_range(0, 16);
                    for (idx = 0; idx < m; idx++)
                        str_q.push_back(cmd_byte());
                    if ($urandom_range(0, 2) != 0)
                        str_q.push_back(CH_CLOSE);
                end
                9:
                begin
                    b = 8'($urandom_range(0, 255));
                    str_q.push_back(b);
                end
                10: str_q.push_back(8'h00);
                default: str_q.push_back(8'hFF);
            endcase
        end
        for (idx = 0; idx < str_q.size(); idx++)
            push_byte(str_q[idx], idx == str_q.size() - 1);
    endtask

    // Sender: offer queued bytes, predict on each accepted beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push     <= 1'b0;
            item     <= '0;
            gap_left = 0;
        end
        else
        begin
            took = push && !full;
            if (took)
            begin
                predict_codes(item);
                bytes_in++;
                if (item.in_end)
                    strings_in++;
                gap_left = calm_tx ? 0 : $urandom_range(0, 5);
                if ($urandom_range(0, 31) == 0)
                    calm_tx = !calm_tx;
            end
            hold_tx = (loaded_cnt == directed_n || loaded_cnt == MID_PAUSE)
                      && code_q.size() != 0;
            if (push && !took)
            begin
                // hold the offered beat
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                push <= 1'b0;
            end
            else if (pend_q.size() > 0 && !hold_tx)
            begin
                item <= pend_q.pop_front();
                push <= 1'b1;
                loaded_cnt++;
            end
            else
                push <= 1'b0;
        end
    end

    // Receiver: check each accepted beat against the oldest expected unit
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop       <= 1'b0;
            wait_left = 0;
            hold_left = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                units_out++;
                if (code_q.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unit %0d: nothing expected, got %h/%b/%b", units_out,
                                 result.code_unit, result.run_last, result.string_done);
                end
                else
                begin
                    exp_unit = code_q.pop_front();
                    if (result.code_unit !== exp_unit.code_unit
                        || result.run_last !== exp_unit.run_last
                        || result.string_done !== exp_unit.string_done)
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("unit %0d: expected %h/%b/%b, got %h/%b/%b", units_out,
                                     exp_unit.code_unit, exp_unit.run_last,
                                     exp_unit.string_done, result.code_unit,
                                     result.run_last, result.string_done);
                    end
                end
                // back off for a long stretch once, so the input side fills up
                if (units_out == HOLD_AT)
                    hold_left = HOLD_LEN;
                else
                    wait_left = calm_rx ? 0 : $urandom_range(0, 5);
                if ($urandom_range(0, 39) == 0)
                    calm_rx = !calm_rx;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (wait_left > 0)
            begin
                wait_left--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d units still expected",
                     cycles, code_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        // directed strings: escapes, bracket and lead-byte corner cases
        push_text("[br]");
        push_text({"[u", "1234567890123", "xQ"});
        push_text("[]");
        push_byte(8'h00, 1'b0);
        push_byte(8'hC3, 1'b0);
        push_byte(CH_OPEN, 1'b1);
        push_byte(8'hD7, 1'b0);
        push_byte(CH_CLOSE, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_text("[u");
        directed_n = pend_q.size();

        // random strings
        while (pend_q.size() < TOTAL_ITEMS)
            add_string();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // drain stimulus, then expected units, then let the block settle
        while (pend_q.size() > 0 || push)
            @(posedge clk);
        while (code_q.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("decoded %0d bytes in %0d strings into %0d code units",
                 bytes_in, strings_in, units_out);
        $display("escapes taken %0d, rejected %0d, two-byte pairs %0d",
                 esc_taken, esc_rejected, pairs_seen);
        if (err_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
